FILE: src/tbt_pkg.sv
// Shared constants, register codes and the temperature conversion helper of the thermistor beta block.
package tbt_pkg;

    // Field widths
    localparam int RES_W   = 24;
    localparam int TEMP_W  = 18;
    localparam int BETA_W  = 20;
    localparam int SCALE_W = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 24;

    // Internal widths
    localparam int KU_W    = 24;   // kelvin in 1/2880 K, signed
    localparam int LOG_W   = 21;   // log2 in Q16, 5 integer bits
    localparam int FRAC_W  = 16;
    localparam int MANT_W  = 31;   // Q30 mantissa
    localparam int MA_W    = 48;   // serial multiplier multiplicand
    localparam int MB_W    = 32;   // serial multiplier multiplier
    localparam int MP_W    = 80;   // serial multiplier product
    localparam int DN_W    = 72;   // divider numerator
    localparam int DD_W    = 53;   // divider divisor
    localparam int DQ_W    = 21;   // divider kept quotient bits
    localparam int PP_W    = 44;   // beta * KSCALE
    localparam int DV_W    = 47;   // denominator D, signed

    // Register indexes
    localparam logic [IDX_W-1:0] REG_R1    = 3'd0;
    localparam logic [IDX_W-1:0] REG_T1    = 3'd1;
    localparam logic [IDX_W-1:0] REG_R2    = 3'd2;
    localparam logic [IDX_W-1:0] REG_T2    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE = 3'd4;

    // Scale codes
    localparam logic [SCALE_W-1:0] SCALE_C = 2'd0;
    localparam logic [SCALE_W-1:0] SCALE_F = 2'd1;

    // Reset values
    localparam logic [RES_W-1:0]  RST_R1   = 24'd160000;
    localparam logic [TEMP_W-1:0] RST_T1   = 18'd1600;
    localparam logic [RES_W-1:0]  RST_R2   = 24'd0;
    localparam logic [TEMP_W-1:0] RST_T2   = 18'd6400;
    localparam logic [BETA_W-1:0] DEFAULT_BETA = 20'd63200;

    // Arithmetic constants
    localparam logic [MB_W-1:0]   LN2_Q32  = 32'd2977044472;
    localparam logic [MB_W-1:0]   KSCALE   = 32'd11796480;
    localparam logic [MB_W-1:0]   K_C_MAG  = 32'd786672;
    localparam logic [MB_W-1:0]   K_F_MAG  = 32'd735472;
    localparam logic [MB_W-1:0]   S_C      = 32'd45;
    localparam logic [MB_W-1:0]   S_F      = 32'd25;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 18'h1FFFF;
    localparam logic [TEMP_W-1:0] TEMP_MIN = 18'h20000;
    localparam logic [DQ_W-1:0]   Q_TMAX   = 21'd131071;
    localparam logic [DQ_W-1:0]   Q_TMIN   = 21'd131072;
    localparam logic [DQ_W-1:0]   Q_BMAX   = 21'd1048575;

    // Temperature in the selected scale to kelvin in 1/2880 K
    function automatic logic [KU_W-1:0] to_ku(input logic [TEMP_W-1:0] t,
                                              input logic [SCALE_W-1:0] scale);
        logic signed [KU_W:0] tw;
        logic signed [KU_W:0] r;
        begin
            tw = {{(KU_W+1-TEMP_W){t[TEMP_W-1]}}, t};
            case (scale)
                SCALE_C: r = tw * 25'sd45 + 25'sd786672;
                SCALE_F: r = (tw - 25'sd2048) * 25'sd25 + 25'sd786672;
                default: r = tw * 25'sd45;
            endcase
            return r[KU_W-1:0];
        end
    endfunction

endpackage

FILE: src/tbt_in_if.sv
// Input channel: one resistance sample per beat.
interface tbt_in_if;
    logic                         valid;
    logic                         ready;
    logic [tbt_pkg::RES_W-1:0]    sample_resistance;

    modport source (output valid, output sample_resistance, input ready);
    modport sink   (input valid, input sample_resistance, output ready);
endinterface

FILE: src/tbt_out_if.sv
// Output channel: one temperature and error flag per beat.
interface tbt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tbt_pkg::TEMP_W-1:0]   temperature;
    logic                                error_flag;

    modport source (output valid, output temperature, output error_flag, input ready);
    modport sink   (input valid, input temperature, input error_flag, output ready);
endinterface

FILE: src/tbt_log2.sv
// Iterative log2 in Q16: serial normalize, then one squaring per fraction bit.
module tbt_log2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tbt_pkg::RES_W-1:0]     i_x,
    output logic                          o_done,
    output logic [tbt_pkg::LOG_W-1:0]     o_log
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_SQ   = 2'd2;

    logic [1:0]                        r_phase;
    logic [tbt_pkg::MANT_W-1:0]        r_m;
    logic [4:0]                        r_cnt;
    logic [3:0]                        r_it;
    logic [tbt_pkg::FRAC_W-1:0]        r_frac;
    logic                              r_done;
    logic [2*tbt_pkg::MANT_W-1:0]      sq;
    logic [tbt_pkg::MANT_W:0]          m2;

    // Square of the mantissa, back to Q30
    assign sq = r_m * r_m;
    assign m2 = sq[2*tbt_pkg::MANT_W-1:tbt_pkg::MANT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_m     <= {{(tbt_pkg::MANT_W-tbt_pkg::RES_W){1'b0}}, i_x};
                        r_cnt   <= 5'd0;
                        r_phase <= PH_NORM;
                    end
                end
                // one left shift per cycle until bit 30 is set
                PH_NORM: begin
                    if (r_m[tbt_pkg::MANT_W-1] || r_cnt == 5'd30) begin
                        r_it    <= 4'd0;
                        r_frac  <= '0;
                        r_phase <= PH_SQ;
                    end else begin
                        r_m   <= {r_m[tbt_pkg::MANT_W-2:0], 1'b0};
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                // one fraction bit per cycle
                PH_SQ: begin
                    r_frac <= {r_frac[tbt_pkg::FRAC_W-2:0], m2[tbt_pkg::MANT_W]};
                    r_m    <= m2[tbt_pkg::MANT_W] ? m2[tbt_pkg::MANT_W:1]
                                                  : m2[tbt_pkg::MANT_W-1:0];
                    r_it   <= r_it + 4'd1;
                    if (r_it == 4'd15) begin
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_log  = {5'(5'd30 - r_cnt), r_frac};
endmodule

FILE: src/tbt_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module tbt_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tbt_pkg::MA_W-1:0]    i_a,
    input  logic [tbt_pkg::MB_W-1:0]    i_b,
    output logic                        o_done,
    output logic [tbt_pkg::MP_W-1:0]    o_prod
);
    logic                        r_run;
    logic                        r_done;
    logic [tbt_pkg::MP_W-1:0]    r_acc;
    logic [tbt_pkg::MP_W-1:0]    r_a;
    logic [tbt_pkg::MB_W-1:0]    r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_run) begin
                r_acc <= '0;
                r_a   <= tbt_pkg::MP_W'(i_a);
                r_b   <= i_b;
                r_run <= 1'b1;
            end else if (r_run) begin
                // stop once no multiplier bits are left
                if (r_b == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_b[0]) r_acc <= r_acc + r_a;
                    r_a <= {r_a[tbt_pkg::MP_W-2:0], 1'b0};
                    r_b <= {1'b0, r_b[tbt_pkg::MB_W-1:1]};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

FILE: src/tbt_div.sv
// Restoring divider: one quotient bit per cycle, low quotient bits kept plus overflow.
module tbt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tbt_pkg::DN_W-1:0]    i_num,
    input  logic [tbt_pkg::DD_W-1:0]    i_den,
    output logic                        o_done,
    output logic [tbt_pkg::DQ_W-1:0]    o_quo,
    output logic                        o_ovf
);
    logic                        r_run;
    logic                        r_done;
    logic [tbt_pkg::DN_W-1:0]    r_n;
    logic [tbt_pkg::DD_W-1:0]    r_den;
    logic [tbt_pkg::DD_W-1:0]    r_rem;
    logic [tbt_pkg::DQ_W-1:0]    r_q;
    logic                        r_ovf;
    logic [6:0]                  r_cnt;
    logic [tbt_pkg::DD_W:0]      trial;
    logic                        ge;

    assign trial = {r_rem, r_n[tbt_pkg::DN_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_run) begin
                r_n   <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                // shift in one numerator bit, subtract when it fits
                r_rem <= ge ? tbt_pkg::DD_W'(trial - {1'b0, r_den})
                            : trial[tbt_pkg::DD_W-1:0];
                r_n   <= {r_n[tbt_pkg::DN_W-2:0], 1'b0};
                r_q   <= {r_q[tbt_pkg::DQ_W-2:0], ge};
                r_ovf <= r_ovf | r_q[tbt_pkg::DQ_W-1];
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(tbt_pkg::DN_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;
endmodule

FILE: src/thermistor_beta_temperature.sv
// Per sample: two serial log2 runs (7 to 30 normalize shifts plus 16 squarings), six bit-serial
// multiplies at one multiplier bit per cycle and a 72-step divider; a zero sample or R1 goes
// straight to a saturated error result. Throughput: one item at a time; unless a beta recompute
// is pending, the next beat is taken the cycle after the result enters the output register. A
// write to registers 0..4 requests a beta recompute, run from idle when the calibration is valid;
// no input beat is taken while it is pending or running. Reset is synchronous active low; it loads
// the calibration registers and the default beta and empties the output register.
module thermistor_beta_temperature (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tbt_in_if.sink                         i_sample,
    tbt_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [tbt_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [tbt_pkg::CFG_W-1:0]      i_cfg_data
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOGA = 4'd1;
    localparam logic [3:0] ST_LOGB = 4'd2;
    localparam logic [3:0] ST_LN   = 4'd3;
    localparam logic [3:0] ST_P    = 4'd4;
    localparam logic [3:0] ST_TL   = 4'd5;
    localparam logic [3:0] ST_NUM1 = 4'd6;
    localparam logic [3:0] ST_NUM2 = 4'd7;
    localparam logic [3:0] ST_UD   = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;
    localparam logic [3:0] ST_BTL  = 4'd11;
    localparam logic [3:0] ST_BTT  = 4'd12;
    localparam logic [3:0] ST_BDEN = 4'd13;

    // Calibration registers and beta
    logic [tbt_pkg::RES_W-1:0]    r_r1, r_r2;
    logic [tbt_pkg::TEMP_W-1:0]   r_t1, r_t2;
    logic [tbt_pkg::SCALE_W-1:0]  r_scale;
    logic [tbt_pkg::BETA_W-1:0]   r_beta;
    logic                         r_bpend;

    // Sequencer and working registers
    logic [3:0]                   r_state;
    logic                         r_job;    // 1: beta recompute
    logic                         r_iss;
    logic [tbt_pkg::RES_W-1:0]    r_opa, r_opb;
    logic [tbt_pkg::KU_W-1:0]     r_t1k, r_t2k;
    logic [tbt_pkg::KU_W-1:0]     r_dt;
    logic                         r_dtneg;
    logic [tbt_pkg::SCALE_W-1:0]  r_scl;
    logic [tbt_pkg::LOG_W-1:0]    r_la, r_lb, r_lq;
    logic                         r_lqneg;
    logic [tbt_pkg::PP_W-1:0]     r_p;
    logic [tbt_pkg::DV_W-1:0]     r_d;
    logic [tbt_pkg::DN_W-1:0]     r_acc, r_num;
    logic [tbt_pkg::DD_W-1:0]     r_ud;
    logic                         r_neg;
    logic [tbt_pkg::TEMP_W-1:0]   r_res;
    logic                         r_rerr;

    // Output register
    logic                         r_ov;
    logic [tbt_pkg::TEMP_W-1:0]   r_otemp;
    logic                         r_oerr;

    // Unit handshakes
    logic                         log_start, log_done;
    logic [tbt_pkg::RES_W-1:0]    log_x;
    logic [tbt_pkg::LOG_W-1:0]    log_out;
    logic                         mul_start, mul_done;
    logic [tbt_pkg::MA_W-1:0]     mul_a;
    logic [tbt_pkg::MB_W-1:0]     mul_b;
    logic [tbt_pkg::MP_W-1:0]     mul_p;
    logic                         div_start, div_done, div_ovf;
    logic [tbt_pkg::DQ_W-1:0]     div_q;

    // Derived values
    logic                         in_ready, in_fire, cfg_hit;
    logic [tbt_pkg::KU_W-1:0]     n_t1k, n_t2k, cur_t1k;
    logic [tbt_pkg::KU_W:0]       n_dt;
    logic                         beta_ok;
    logic [tbt_pkg::LOG_W:0]      dif;
    logic [tbt_pkg::LOG_W-1:0]    dif_mag;
    logic [tbt_pkg::KU_W-1:0]     t1_mag, t2_mag;
    logic [tbt_pkg::DV_W-1:0]     d_mag;
    logic [53:0]                  n_lqw;
    logic [tbt_pkg::LOG_W-1:0]    n_lq;
    logic [tbt_pkg::DV_W-1:0]     tl_term, n_d;
    logic [tbt_pkg::DN_W-1:0]     acc_mag;

    assign in_ready = (r_state == ST_IDLE) && !r_bpend;
    assign in_fire  = i_sample.valid && in_ready;
    assign cfg_hit  = i_cfg_we && (i_cfg_index <= tbt_pkg::REG_SCALE);

    // Beta preconditions from the live registers
    assign n_t1k   = tbt_pkg::to_ku(r_t1, r_scale);
    assign n_t2k   = tbt_pkg::to_ku(r_t2, r_scale);
    assign cur_t1k = n_t1k;
    assign n_dt    = {n_t2k[tbt_pkg::KU_W-1], n_t2k} - {n_t1k[tbt_pkg::KU_W-1], n_t1k};
    assign beta_ok = (r_r1 != '0) && (r_r2 != '0) && (n_t1k != '0) && (n_t2k != '0)
                     && (n_dt != '0);

    // Magnitudes
    assign dif     = {1'b0, r_la} - {1'b0, r_lb};
    assign dif_mag = dif[tbt_pkg::LOG_W] ? tbt_pkg::LOG_W'(~dif + 1'b1)
                                         : dif[tbt_pkg::LOG_W-1:0];
    assign t1_mag  = r_t1k[tbt_pkg::KU_W-1] ? (~r_t1k + 1'b1) : r_t1k;
    assign t2_mag  = r_t2k[tbt_pkg::KU_W-1] ? (~r_t2k + 1'b1) : r_t2k;
    assign d_mag   = r_d[tbt_pkg::DV_W-1] ? (~r_d + 1'b1) : r_d;
    assign acc_mag = r_acc[tbt_pkg::DN_W-1] ? (~r_acc + 1'b1) : r_acc;

    // ln rounding and the denominator D
    assign n_lqw   = mul_p[53:0] + 54'h0_0000_8000_0000;
    assign n_lq    = n_lqw[52:32];
    assign tl_term = (r_t1k[tbt_pkg::KU_W-1] ^ r_lqneg)
                     ? (~tbt_pkg::DV_W'(mul_p[44:0]) + 1'b1) : tbt_pkg::DV_W'(mul_p[44:0]);
    assign n_d     = tbt_pkg::DV_W'(r_p) + tl_term;

    // Unit starts and operands
    assign log_start = !r_iss && (r_state == ST_LOGA || r_state == ST_LOGB);
    assign log_x     = (r_state == ST_LOGA) ? r_opa : r_opb;
    assign div_start = !r_iss && (r_state == ST_DIV);

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            ST_LN: begin
                mul_start = !r_iss;
                mul_a     = tbt_pkg::MA_W'(dif_mag);
                mul_b     = tbt_pkg::LN2_Q32;
            end
            ST_P: begin
                mul_start = !r_iss;
                mul_a     = tbt_pkg::MA_W'(r_beta);
                mul_b     = tbt_pkg::KSCALE;
            end
            ST_TL, ST_BTL: begin
                mul_start = !r_iss;
                mul_a     = tbt_pkg::MA_W'(r_lq);
                mul_b     = tbt_pkg::MB_W'(t1_mag);
            end
            ST_NUM1: begin
                mul_start = !r_iss;
                mul_a     = tbt_pkg::MA_W'(r_p);
                mul_b     = tbt_pkg::MB_W'(t1_mag);
            end
            ST_NUM2: begin
                mul_start = !r_iss;
                mul_a     = tbt_pkg::MA_W'(d_mag);
                case (r_scl)
                    tbt_pkg::SCALE_C: mul_b = tbt_pkg::K_C_MAG;
                    tbt_pkg::SCALE_F: mul_b = tbt_pkg::K_F_MAG;
                    default:          mul_b = '0;
                endcase
            end
            ST_UD: begin
                mul_start = !r_iss;
                mul_a     = tbt_pkg::MA_W'(d_mag);
                mul_b     = (r_scl == tbt_pkg::SCALE_F) ? tbt_pkg::S_F : tbt_pkg::S_C;
            end
            ST_BTT: begin
                mul_start = !r_iss;
                mul_a     = r_num[tbt_pkg::MA_W-1:0];
                mul_b     = tbt_pkg::MB_W'(t2_mag);
            end
            ST_BDEN: begin
                mul_start = !r_iss;
                mul_a     = tbt_pkg::MA_W'(r_dt);
                mul_b     = tbt_pkg::KSCALE;
            end
            default: ;
        endcase
    end

    tbt_log2 u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_out)
    );

    tbt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    tbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_ud),
        .o_done  (div_done),
        .o_quo   (div_q),
        .o_ovf   (div_ovf)
    );

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1    <= tbt_pkg::RST_R1;
            r_t1    <= tbt_pkg::RST_T1;
            r_r2    <= tbt_pkg::RST_R2;
            r_t2    <= tbt_pkg::RST_T2;
            r_scale <= tbt_pkg::SCALE_C;
            r_beta  <= tbt_pkg::DEFAULT_BETA;
            r_bpend <= 1'b0;
            r_state <= ST_IDLE;
            r_job   <= 1'b0;
            r_iss   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tbt_pkg::REG_R1:    r_r1    <= i_cfg_data[tbt_pkg::RES_W-1:0];
                    tbt_pkg::REG_T1:    r_t1    <= i_cfg_data[tbt_pkg::TEMP_W-1:0];
                    tbt_pkg::REG_R2:    r_r2    <= i_cfg_data[tbt_pkg::RES_W-1:0];
                    tbt_pkg::REG_T2:    r_t2    <= i_cfg_data[tbt_pkg::TEMP_W-1:0];
                    tbt_pkg::REG_SCALE: r_scale <= i_cfg_data[tbt_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end

            // the output stage reloads the register itself
            if (r_ov && o_result.ready && r_state != ST_OUT) r_ov <= 1'b0;
            if (log_start || mul_start || div_start) r_iss <= 1'b1;

            unique case (r_state)
                ST_IDLE: begin
                    if (r_bpend) begin
                        // launch a beta recompute on a snapshot of the registers when they are valid
                        if (beta_ok) begin
                            r_opa   <= r_r1;
                            r_opb   <= r_r2;
                            r_t1k   <= n_t1k;
                            r_t2k   <= n_t2k;
                            r_dtneg <= n_dt[tbt_pkg::KU_W];
                            r_dt    <= n_dt[tbt_pkg::KU_W] ? tbt_pkg::KU_W'(~n_dt + 1'b1)
                                                           : n_dt[tbt_pkg::KU_W-1:0];
                            r_job   <= 1'b1;
                            r_state <= ST_LOGA;
                        end
                    end else if (in_fire) begin
                        if (i_sample.sample_resistance == '0 || r_r1 == '0) begin
                            r_res   <= tbt_pkg::TEMP_MAX;
                            r_rerr  <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_opa   <= i_sample.sample_resistance;
                            r_opb   <= r_r1;
                            r_t1k   <= cur_t1k;
                            r_scl   <= r_scale;
                            r_job   <= 1'b0;
                            r_state <= ST_LOGA;
                        end
                    end
                end
                ST_LOGA: begin
                    if (log_done) begin
                        r_la    <= log_out;
                        r_iss   <= 1'b0;
                        r_state <= ST_LOGB;
                    end
                end
                ST_LOGB: begin
                    if (log_done) begin
                        r_lb    <= log_out;
                        r_iss   <= 1'b0;
                        r_state <= ST_LN;
                    end
                end
                // ln of the ratio, rounded half away from zero
                ST_LN: begin
                    if (mul_done) begin
                        r_lq    <= n_lq;
                        r_lqneg <= dif[tbt_pkg::LOG_W];
                        r_iss   <= 1'b0;
                        if (!r_job) begin
                            r_state <= ST_P;
                        end else if (n_lq == '0 ||
                                     ((dif[tbt_pkg::LOG_W] ^ r_t1k[tbt_pkg::KU_W-1]) ^
                                      (r_t2k[tbt_pkg::KU_W-1] ^ r_dtneg))) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_BTL;
                        end
                    end
                end
                ST_P: begin
                    if (mul_done) begin
                        r_p     <= mul_p[tbt_pkg::PP_W-1:0];
                        r_iss   <= 1'b0;
                        r_state <= ST_TL;
                    end
                end
                // D = P + T1 * ln
                ST_TL: begin
                    if (mul_done) begin
                        r_d   <= n_d;
                        r_iss <= 1'b0;
                        if (n_d == '0) begin
                            r_res   <= tbt_pkg::TEMP_MAX;
                            r_rerr  <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_NUM1;
                        end
                    end
                end
                ST_NUM1: begin
                    if (mul_done) begin
                        r_acc   <= r_t1k[tbt_pkg::KU_W-1] ? (~mul_p[tbt_pkg::DN_W-1:0] + 1'b1)
                                                          : mul_p[tbt_pkg::DN_W-1:0];
                        r_iss   <= 1'b0;
                        r_state <= ST_NUM2;
                    end
                end
                // K is never positive: add |K*D| when D is negative
                ST_NUM2: begin
                    if (mul_done) begin
                        r_acc   <= r_d[tbt_pkg::DV_W-1] ? (r_acc + mul_p[tbt_pkg::DN_W-1:0])
                                                        : (r_acc - mul_p[tbt_pkg::DN_W-1:0]);
                        r_iss   <= 1'b0;
                        r_state <= ST_UD;
                    end
                end
                ST_UD: begin
                    if (mul_done) begin
                        r_ud    <= mul_p[tbt_pkg::DD_W-1:0];
                        r_num   <= acc_mag + tbt_pkg::DN_W'(mul_p[tbt_pkg::DD_W-1:1]);
                        r_neg   <= r_acc[tbt_pkg::DN_W-1] ^ r_d[tbt_pkg::DV_W-1];
                        r_iss   <= 1'b0;
                        r_state <= ST_DIV;
                    end
                end
                ST_BTL: begin
                    if (mul_done) begin
                        r_num   <= tbt_pkg::DN_W'(mul_p[44:0]);
                        r_iss   <= 1'b0;
                        r_state <= ST_BTT;
                    end
                end
                ST_BTT: begin
                    if (mul_done) begin
                        r_num   <= mul_p[tbt_pkg::DN_W-1:0];
                        r_iss   <= 1'b0;
                        r_state <= ST_BDEN;
                    end
                end
                ST_BDEN: begin
                    if (mul_done) begin
                        r_ud    <= mul_p[tbt_pkg::DD_W-1:0];
                        r_num   <= r_num + tbt_pkg::DN_W'(mul_p[tbt_pkg::DD_W-1:1]);
                        r_iss   <= 1'b0;
                        r_state <= ST_DIV;
                    end
                end
                // quotient: new beta, or the temperature, saturated on overflow
                ST_DIV: begin
                    if (div_done) begin
                        r_iss <= 1'b0;
                        if (r_job) begin
                            if (!div_ovf && div_q != '0 && div_q <= tbt_pkg::Q_BMAX)
                                r_beta <= div_q[tbt_pkg::BETA_W-1:0];
                            r_state <= ST_IDLE;
                        end else begin
                            if (r_neg) begin
                                if (div_ovf || div_q > tbt_pkg::Q_TMIN) begin
                                    r_res  <= tbt_pkg::TEMP_MIN;
                                    r_rerr <= 1'b1;
                                end else begin
                                    r_res  <= ~div_q[tbt_pkg::TEMP_W-1:0] + 1'b1;
                                    r_rerr <= 1'b0;
                                end
                            end else begin
                                if (div_ovf || div_q > tbt_pkg::Q_TMAX) begin
                                    r_res  <= tbt_pkg::TEMP_MAX;
                                    r_rerr <= 1'b1;
                                end else begin
                                    r_res  <= div_q[tbt_pkg::TEMP_W-1:0];
                                    r_rerr <= 1'b0;
                                end
                            end
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_ov || o_result.ready) begin
                        r_otemp <= r_res;
                        r_oerr  <= r_rerr;
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // pending beta recompute
            if (cfg_hit)
                r_bpend <= 1'b1;
            else if (r_state == ST_IDLE && r_bpend)
                r_bpend <= 1'b0;
        end
    end

    assign i_sample.ready       = in_ready;
    assign o_result.valid       = r_ov;
    assign o_result.temperature = r_otemp;
    assign o_result.error_flag  = r_oerr;
endmodule

FILE: src/tbt_chk.sv
// Port-level checks of the thermistor beta block, bound to the top level.
module tbt_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [tbt_pkg::TEMP_W-1:0]       out_temp,
    input  logic                             cfg_we,
    input  logic [tbt_pkg::IDX_W-1:0]        cfg_index
);
    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_temp))
        else $error("result beat dropped or changed while stalled");

    // one item at a time: no beat taken right after one is accepted
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a write to registers 0..4 closes the input right after it
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we && (cfg_index <= tbt_pkg::REG_SCALE) |=> !in_ready)
        else $error("input open during beta recompute");

    // a result only appears after an item was in flight
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without an item in flight");
endmodule

bind thermistor_beta_temperature tbt_chk u_tbt_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_sample.valid),
    .in_ready  (i_sample.ready),
    .out_valid (o_result.valid),
    .out_ready (o_result.ready),
    .out_temp  (o_result.temperature),
    .cfg_we    (i_cfg_we),
    .cfg_index (i_cfg_index)
);
